/* rtl/lphs_pkg.sv */
package lphs_pkg;
  localparam int CAPACITY_DEF = 256;
  localparam int KEY_BITS_DEF = 64;
  localparam int FP_BITS_DEF  = 7;

  typedef enum logic [2:0] {
    MODE_LOOKUP = 3'd0, MODE_GET_OR_PUT = 3'd1, MODE_INSERT_NEW = 3'd2,
    MODE_REMOVE = 3'd3, MODE_CLEAR = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_FOUND = 3'd0, ST_INSERTED = 3'd1, ST_REMOVED = 3'd2, ST_MISSING = 3'd3,
    ST_EMPTY = 3'd4, ST_FULL = 3'd5, ST_CLEARED = 3'd6
  } status_t;

  localparam logic [3:0] REG_CAPACITY_LOG2 = 4'd0;
  localparam logic [3:0] REG_MAX_ENTRIES   = 4'd1;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch request, start probe
    logic restart;   // rewind probe to home slot
    logic rd;        // issue slot read at probe pointer
    logic step;      // advance probe pointer
    logic note_tomb; // remember first tombstone
    logic put;       // write meta+key at fill slot
    logic tomb;      // write tombstone at probe pointer
    logic clr;       // write open at clear pointer
    logic clr_step;
    logic count_inc;
    logic count_dec;
    logic count_zero;
    logic use_tomb;  // fill slot = remembered tombstone
    logic res_load;
    status_t res_status;
    logic res_slot;  // report probe/fill slot
  } lphs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    mode_t  mode;
    logic   is_open;
    logic   is_tomb;
    logic   is_used;
    logic   hit;
    logic   lap_done;
    logic   have_tomb;
    logic   at_limit;
    logic   count_zero;
    logic   clr_done;
    logic   out_busy;
  } lphs_sts_t;
endpackage

/* rtl/lphs_if.sv */
interface lphs_in_if #(parameter int KEY_W = 64) (input logic clk);
  logic             valid;
  logic             ready;
  logic [2:0]       mode;
  logic [KEY_W-1:0] key;
  logic [63:0]      key_hash;
  modport source (output valid, mode, key, key_hash, input ready);
  modport sink   (input valid, mode, key, key_hash, output ready);
endinterface

interface lphs_out_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] slot_index;
  logic [7:0] entry_total;
  modport source (output valid, status, slot_index, entry_total, input ready);
  modport sink   (input valid, status, slot_index, entry_total, output ready);
endinterface

/* rtl/lphs_ram.sv */
module lphs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* rtl/lphs_ctrl.sv */
module lphs_ctrl import lphs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  lphs_sts_t sts,
  output lphs_cmd_t cmd
);
  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_EVAL  = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_CLEAR = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   scan_r, scan_nxt;   // get_or_put second pass: home slot read still to issue

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      scan_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      scan_r  <= scan_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE) && !sts.out_busy;

  always_comb begin
    state_nxt = state_r;
    scan_nxt  = scan_r;
    cmd       = '0;
    cmd.res_status = ST_MISSING;
    unique case (state_r)
      S_INIT: begin
        cmd.clr      = 1'b1;
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          scan_nxt  = 1'b0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        priority case (1'b1)
          sts.mode == MODE_CLEAR: begin
            cmd.count_zero = 1'b1;
            state_nxt      = S_CLEAR;
          end
          sts.mode == MODE_INSERT_NEW && sts.at_limit: begin
            cmd.res_load = 1'b1; cmd.res_status = ST_FULL;
            state_nxt = S_DONE;
          end
          (sts.mode == MODE_LOOKUP || sts.mode == MODE_REMOVE ||
           sts.mode > MODE_CLEAR) && sts.count_zero: begin
            cmd.res_load = 1'b1; cmd.res_status = ST_EMPTY;
            state_nxt = S_DONE;
          end
          default: begin
            cmd.rd    = 1'b1;
            state_nxt = (sts.mode == MODE_INSERT_NEW) ? S_SCAN : S_EVAL;
          end
        endcase
      end
      S_EVAL: begin
        // find pass: meta/key of probe slot now valid
        if (sts.hit) begin
          cmd.res_load = 1'b1;
          cmd.res_slot = 1'b1;
          if (sts.mode == MODE_REMOVE) begin
            cmd.tomb = 1'b1; cmd.count_dec = 1'b1; cmd.res_status = ST_REMOVED;
          end else begin
            cmd.res_status = ST_FOUND;
          end
          state_nxt = S_DONE;
        end else if (sts.is_open || sts.lap_done) begin
          if (sts.mode == MODE_GET_OR_PUT) begin
            if (sts.at_limit) begin
              cmd.res_load = 1'b1; cmd.res_status = ST_FULL;
              state_nxt = S_DONE;
            end else begin
              cmd.restart = 1'b1;  // restart probe at home slot
              scan_nxt  = 1'b1;
              state_nxt = S_SCAN;
            end
          end else begin
            cmd.res_load = 1'b1; cmd.res_status = ST_MISSING;
            state_nxt = S_DONE;
          end
        end else begin
          cmd.step  = 1'b1;
          cmd.rd    = 1'b1;
        end
      end
      S_SCAN: begin
        if (scan_r) begin
          // first cycle after restart issues read of home slot
          cmd.rd = 1'b1;
          scan_nxt = 1'b0;
        end else if (sts.mode == MODE_INSERT_NEW) begin
          if (!sts.is_used) begin
            cmd.put = 1'b1; cmd.count_inc = 1'b1;
            cmd.res_load = 1'b1; cmd.res_slot = 1'b1; cmd.res_status = ST_INSERTED;
            state_nxt = S_DONE;
          end else if (sts.lap_done) begin
            cmd.res_load = 1'b1; cmd.res_status = ST_FULL;
            state_nxt = S_DONE;
          end else begin
            cmd.step = 1'b1; cmd.rd = 1'b1;
          end
        end else begin
          if (sts.is_open || (sts.lap_done && (sts.have_tomb || sts.is_tomb))) begin
            cmd.use_tomb = sts.have_tomb || sts.is_tomb && !sts.is_open;
            cmd.note_tomb = sts.is_tomb && !sts.have_tomb;
            cmd.put = 1'b1; cmd.count_inc = 1'b1;
            cmd.res_load = 1'b1; cmd.res_slot = 1'b1; cmd.res_status = ST_INSERTED;
            state_nxt = S_DONE;
          end else if (sts.lap_done) begin
            cmd.res_load = 1'b1; cmd.res_status = ST_FULL;
            state_nxt = S_DONE;
          end else begin
            cmd.note_tomb = sts.is_tomb && !sts.have_tomb;
            cmd.step = 1'b1; cmd.rd = 1'b1;
          end
        end
      end
      S_CLEAR: begin
        cmd.clr      = 1'b1;
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          cmd.res_load = 1'b1; cmd.res_status = ST_CLEARED;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end
endmodule

/* rtl/lphs_dp.sv */
module lphs_dp import lphs_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF,
  parameter int FP_BITS  = FP_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [2:0]    in_mode,
  input  logic [63:0]   in_key,
  input  logic [63:0]   in_key_hash,
  input  logic          cfg_we,
  input  logic [3:0]    cfg_index,
  input  logic [7:0]    cfg_wdata,
  input  lphs_cmd_t     cmd,
  output lphs_sts_t     sts,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    out_status,
  output logic [7:0]    out_slot_index,
  output logic [7:0]    out_entry_total
);
  localparam int AW    = $clog2(CAPACITY);
  localparam int MW    = FP_BITS + 1;
  localparam int CNT_W = AW + 1;

  logic [3:0]          cap_lg_r;
  logic [7:0]          max_r;
  logic [2:0]          mode_r;
  logic [KEY_BITS-1:0] key_r;
  logic [FP_BITS-1:0]  fp_r;
  logic [AW-1:0]       start_r, ptr_r, tomb_r, clr_r, mask_r;
  logic [CNT_W-1:0]    steps_r, cnt_r, limit_r;
  logic                have_tomb_r, clr_done_r;
  logic                vld_r;
  logic [2:0]          st_r;
  logic [7:0]          slot_r;
  logic [7:0]          tot_r;
  logic [AW-1:0]       lg_eff;
  logic [CNT_W-1:0]    slots_m1, limit_w, cnt_out;
  logic [MW-1:0]       meta_rd, meta_wd;
  logic [KEY_BITS-1:0] key_rd;
  logic [AW-1:0]       meta_wa, fill_at, rd_a;
  logic                meta_we;
  logic [AW-1:0]       hash_start;

  always_comb begin
    logic [3:0] lg;
    lg = (cap_lg_r == 4'd0) ? 4'd1 : cap_lg_r;
    if (32'(lg) > AW) begin
      lg = 4'(AW);
    end
    lg_eff = AW'(lg);
  end
  assign slots_m1 = CNT_W'(({{AW{1'b0}}, 1'b1} << lg_eff) - 1'b1);
  assign hash_start = in_key_hash[AW-1:0] & slots_m1[AW-1:0];

  // load limit saturated to slots - 1
  always_comb begin
    int unsigned mx, sm;
    mx = 32'(max_r);
    sm = 32'(slots_m1);
    limit_w = CNT_W'((mx < sm) ? mx : sm);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_lg_r <= 4'd8;
      max_r    <= 8'd204;
    end else if (cfg_we) begin
      if (cfg_index == REG_CAPACITY_LOG2) cap_lg_r <= cfg_wdata[3:0];
      if (cfg_index == REG_MAX_ENTRIES)   max_r    <= cfg_wdata;
    end
  end

  assign rd_a = cmd.step ? ((ptr_r + 1'b1) & mask_r) : ptr_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      key_r   <= in_key[KEY_BITS-1:0];
      fp_r    <= in_key_hash[63 -: FP_BITS];
      start_r <= hash_start;
      ptr_r   <= hash_start;
      mask_r  <= slots_m1[AW-1:0];
      limit_r <= limit_w;
      steps_r <= '0;
      have_tomb_r <= 1'b0;
    end else if (cmd.restart) begin
      ptr_r   <= start_r;
      steps_r <= '0;
      have_tomb_r <= 1'b0;
    end else if (cmd.step) begin
      ptr_r   <= rd_a;
      steps_r <= steps_r + 1'b1;
    end
    if (cmd.note_tomb) begin
      tomb_r      <= ptr_r;
      have_tomb_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.count_zero) begin
      cnt_r <= '0;
    end else if (cmd.count_inc) begin
      cnt_r <= cnt_r + 1'b1;
    end else if (cmd.count_dec) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0; clr_done_r <= 1'b0;
    end else if (cmd.clr_step) begin
      clr_r      <= clr_r + 1'b1;
      clr_done_r <= (clr_r == AW'(CAPACITY - 2));
    end else begin
      clr_done_r <= 1'b0;
    end
  end

  assign fill_at = cmd.use_tomb ? (have_tomb_r ? tomb_r : ptr_r) : ptr_r;
  always_comb begin
    meta_we = cmd.clr | cmd.put | cmd.tomb;
    meta_wa = cmd.clr ? clr_r : fill_at;
    meta_wd = cmd.put ? {1'b1, fp_r} : (cmd.tomb ? MW'(1) : '0);
  end

  lphs_ram #(.WIDTH(MW), .DEPTH(CAPACITY)) u_meta (
    .clk, .we(meta_we), .waddr(meta_wa), .wdata(meta_wd),
    .re(cmd.rd), .raddr(rd_a), .rdata(meta_rd)
  );
  lphs_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_keys (
    .clk, .we(cmd.put), .waddr(fill_at), .wdata(key_r),
    .re(cmd.rd), .raddr(rd_a), .rdata(key_rd)
  );

  always_comb begin
    sts           = '0;
    sts.mode      = mode_t'(mode_r);
    sts.is_open   = meta_rd == '0;
    sts.is_tomb   = meta_rd == MW'(1);
    sts.is_used   = meta_rd[MW-1];
    sts.hit       = meta_rd == {1'b1, fp_r} && key_rd == key_r;
    sts.lap_done  = steps_r == CNT_W'(mask_r);
    sts.have_tomb = have_tomb_r;
    sts.at_limit  = cnt_r >= limit_r;
    sts.count_zero = cnt_r == '0;
    sts.clr_done  = clr_done_r;
    sts.out_busy  = vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (cmd.res_load) begin
      vld_r <= 1'b1;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
    if (cmd.res_load) begin
      st_r   <= cmd.res_status;
      slot_r <= cmd.res_slot ? 8'(fill_at) : 8'd0;
    end
  end

  assign cnt_out = cnt_r + CNT_W'(cmd.count_inc) - CNT_W'(cmd.count_dec);
  always_ff @(posedge clk) begin
    if (cmd.res_load) tot_r <= cmd.count_zero ? 8'd0 : 8'(cnt_out);
  end

  assign out_valid       = vld_r;
  assign out_status      = st_r;
  assign out_slot_index  = slot_r;
  assign out_entry_total = tot_r;
endmodule

/* rtl/linear_probe_hash_set.sv */
// Linear-probing hash set.
// Input channel in_*: mode, key, key_hash; one result item on out_* per item.
// Config: cfg_we/cfg_index/cfg_wdata, write only while idle.
// One item in flight: the controller walks slot memory one slot per cycle
// through the registered read port of the meta and key RAMs.
// Lookup and remove on an empty table, and insert_new at the limit, answer
// without reading a slot; a get_or_put that places a key walks a second pass.
// Reset: synchronous, rst_n low. After reset a pass opens every slot
// while in_ready stays low.
// Stall: the result waits in the output register; no new item is taken
// until it is delivered.
module linear_probe_hash_set import lphs_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF,
  parameter int FP_BITS  = FP_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lphs_in_if.sink    in_ch,
  lphs_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [3:0] cfg_index,
  input  logic [7:0] cfg_wdata
);
  lphs_cmd_t cmd;
  lphs_sts_t sts;

  lphs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .sts, .cmd
  );

  lphs_dp #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS), .FP_BITS(FP_BITS)) u_dp (
    .clk, .rst_n,
    .in_mode(in_ch.mode), .in_key(64'(in_ch.key)), .in_key_hash(in_ch.key_hash),
    .cfg_we, .cfg_index, .cfg_wdata, .cmd, .sts,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_status(out_ch.status),
    .out_slot_index(out_ch.slot_index), .out_entry_total(out_ch.entry_total)
  );

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("accept with result pending");
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.put && cmd.tomb)) else $error("two slot writes");
`endif
endmodule

/* sim/tb_linear_probe_hash_set.sv */
module tb_linear_probe_hash_set;
  import lphs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SLOTS_MAX   = 256;
  localparam logic [7:0]  META_USED   = 8'h80;
  localparam logic [7:0]  META_TOMB   = 8'h01;
  localparam logic [2:0]  MODE_SPARE_LO = 3'd5;
  localparam logic [2:0]  MODE_SPARE_MID = 3'd6;
  localparam logic [2:0]  MODE_SPARE_HI = 3'd7;
  localparam int          CYCLE_LIMIT = 3000000;
  localparam int          LONG_HOLD   = 300;
  localparam int          PHASE_ITEMS = 170;
  localparam int          POOL_N      = 16;

  typedef struct packed {
    status_t    status;
    logic [7:0] slot;
    logic [7:0] total;
  } reply_t;

  typedef struct {
    logic [2:0]  mode;
    logic [63:0] key;
    logic [63:0] hash;
    bit          typed;
    reply_t      want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [3:0] cfg_index = REG_CAPACITY_LOG2;
  logic [7:0] cfg_wdata = 8'd0;

  lphs_in_if #(.KEY_W(64)) in_ch (clk);
  lphs_out_if              out_ch (clk);

  linear_probe_hash_set i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // shadow of the set
  logic [7:0]  tbl_meta [SLOTS_MAX];
  logic [63:0] tbl_keys [SLOTS_MAX];
  int unsigned tbl_count;
  logic [3:0]  cap_log2_q;
  logic [7:0]  max_entries_q;

  reply_t replies_due[$];
  int     errors = 0;
  int     cycles = 0;
  bit     hold_req = 0;

  task automatic report(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic bit probe_find(input logic [63:0] key, input logic [7:0] fp,
                                    input int start, input int mask, input int slots,
                                    output int at);
    int p;
    p = start;
    at = 0;
    for (int i = 0; i < slots; i++) begin
      if (tbl_meta[p] == 8'h00) return 0;
      if (tbl_meta[p] == (META_USED | fp) && tbl_keys[p] == key) begin
        at = p;
        return 1;
      end
      p = (p + 1) & mask;
    end
    return 0;
  endfunction

  function automatic reply_t hash_set_step(input logic [2:0] mode, input logic [63:0] key,
                                           input logic [63:0] hash);
    int lg, slots, mask, start, at, p, tomb, lim;
    bit have_tomb, have_open;
    logic [7:0] fp;
    reply_t r;
    lg = (cap_log2_q < 1) ? 1 : cap_log2_q;
    if (lg > 8) lg = 8;
    slots = 1 << lg;
    mask = slots - 1;
    lim = (max_entries_q < slots - 1) ? max_entries_q : slots - 1;
    fp = {1'b0, hash[63:57]};
    start = int'(hash[31:0]) & mask;
    r.status = ST_MISSING;
    r.slot = 8'd0;
    if (mode == MODE_CLEAR) begin
      foreach (tbl_meta[i]) tbl_meta[i] = 8'h00;
      tbl_count = 0;
      r.status = ST_CLEARED;
    end else if (mode == MODE_GET_OR_PUT) begin
      if (probe_find(key, fp, start, mask, slots, at)) begin
        r.status = ST_FOUND;
        r.slot = 8'(at);
      end else if (tbl_count >= lim) begin
        r.status = ST_FULL;
      end else begin
        p = start; tomb = 0; have_tomb = 0; have_open = 0;
        for (int i = 0; i < slots; i++) begin
          if (tbl_meta[p] == 8'h00) begin
            have_open = 1;
            break;
          end
          if (!have_tomb && tbl_meta[p] == META_TOMB) begin
            have_tomb = 1;
            tomb = p;
          end
          p = (p + 1) & mask;
        end
        if (have_tomb || have_open) begin
          if (have_tomb) p = tomb;
          tbl_meta[p] = META_USED | fp;
          tbl_keys[p] = key;
          tbl_count++;
          r.status = ST_INSERTED;
          r.slot = 8'(p);
        end else begin
          r.status = ST_FULL;
        end
      end
    end else if (mode == MODE_INSERT_NEW) begin
      r.status = ST_FULL;
      if (tbl_count < lim) begin
        p = start;
        for (int i = 0; i < slots; i++) begin
          if (!(tbl_meta[p] & META_USED)) begin
            tbl_meta[p] = META_USED | fp;
            tbl_keys[p] = key;
            tbl_count++;
            r.status = ST_INSERTED;
            r.slot = 8'(p);
            break;
          end
          p = (p + 1) & mask;
        end
      end
    end else begin
      if (tbl_count == 0) begin
        r.status = ST_EMPTY;
      end else if (probe_find(key, fp, start, mask, slots, at)) begin
        r.slot = 8'(at);
        if (mode == MODE_REMOVE) begin
          tbl_meta[at] = META_TOMB;
          tbl_count--;
          r.status = ST_REMOVED;
        end else begin
          r.status = ST_FOUND;
        end
      end
    end
    r.total = tbl_count[7:0];
    return r;
  endfunction

  // sender: valid stays high across back-to-back items
  task automatic send_item(input logic [2:0] mode, input logic [63:0] key,
                           input logic [63:0] hash, input bit typed, input reply_t want);
    int gap;
    reply_t got;
    gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= mode;
    in_ch.key      <= key;
    in_ch.key_hash <= hash;
    do @(posedge clk); while (!in_ch.ready);
    got = hash_set_step(mode, key, hash);
    replies_due.push_back(typed ? want : got);
  endtask

  task automatic settle;
    if (in_ch.valid) begin
      @(posedge clk);
      in_ch.valid <= 1'b0;
    end
    wait (replies_due.size() == 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [3:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CAPACITY_LOG2) cap_log2_q = val[3:0];
    else max_entries_q = val;
  endtask

  // receiver
  initial begin
    int n;
    bit quiet;
    out_ch.ready = 1'b0;
    quiet = 0;
    @(posedge clk iff rst_n);
    forever begin
      if ($urandom_range(0, 31) == 0) quiet = ~quiet;
      n = quiet ? 0 : $urandom_range(0, 14);
      if (hold_req) begin
        n = LONG_HOLD;
        hold_req = 0;
      end
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (replies_due.size() == 0) begin
        report("item with no expectation");
      end else begin
        want = replies_due.pop_front();
        if (out_ch.status != want.status)
          report($sformatf("status %0d, want %0d", out_ch.status, want.status));
        if (out_ch.slot_index != want.slot)
          report($sformatf("slot_index %0d, want %0d", out_ch.slot_index, want.slot));
        if (out_ch.entry_total != want.total)
          report($sformatf("entry_total %0d, want %0d", out_ch.entry_total, want.total));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** linear_probe_hash_set: FAILED **");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_tab[$];
    logic [63:0] pool_key [POOL_N];
    logic [63:0] pool_hash [POOL_N];
    logic [3:0] ph_cap [8] = '{4'd2, 4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd4, 4'd8};
    logic [7:0] ph_max [8] = '{8'd255, 8'd1, 8'd204, 8'd0, 8'd255, 8'd2, 8'd7, 8'd255};
    logic [2:0] mode;
    logic [63:0] key, hash;
    int k, pick;
    reply_t none;

    none = '{ST_FOUND, 8'd0, 8'd0};
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_LOOKUP;
    in_ch.key = '0;
    in_ch.key_hash = '0;
    foreach (tbl_meta[i]) tbl_meta[i] = 8'h00;
    tbl_count = 0;
    cap_log2_q = 4'd8;
    max_entries_q = 8'd204;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    dir_tab = '{
      '{MODE_LOOKUP, 64'h1234, 64'h0, 1, '{ST_EMPTY, 8'd0, 8'd0}},
      '{MODE_REMOVE, 64'h1234, 64'h0, 1, '{ST_EMPTY, 8'd0, 8'd0}},
      '{MODE_CLEAR, 64'h0, 64'h0, 1, '{ST_CLEARED, 8'd0, 8'd0}},
      '{MODE_GET_OR_PUT, '1, '1, 1, '{ST_INSERTED, 8'd255, 8'd1}},
      '{MODE_GET_OR_PUT, '1, '1, 1, '{ST_FOUND, 8'd255, 8'd1}},
      '{MODE_INSERT_NEW, '1, '1, 1, '{ST_INSERTED, 8'd0, 8'd2}},
      '{MODE_LOOKUP, 64'h0, 64'h0, 1, '{ST_MISSING, 8'd0, 8'd2}},
      '{MODE_INSERT_NEW, 64'h0, 64'h0, 0, none},
      '{MODE_REMOVE, '1, '1, 0, none},
      '{MODE_LOOKUP, '1, '1, 0, none},
      '{MODE_GET_OR_PUT, 64'h5, 64'hFF, 0, none},
      '{MODE_GET_OR_PUT, 64'h5, 64'h8000_0000_0000_00FF, 0, none},
      '{MODE_SPARE_LO, 64'h0, 64'h0, 0, none},
      '{MODE_SPARE_MID, 64'h5, 64'hFF, 0, none},
      '{MODE_SPARE_HI, '1, '1, 0, none},
      '{MODE_REMOVE, 64'h0, 64'h0, 0, none},
      '{MODE_REMOVE, 64'h0, 64'h0, 0, none},
      '{MODE_LOOKUP, 64'hAAAA_5555_AAAA_5555, 64'h5555_AAAA_5555_AAAA, 0, none},
      '{MODE_CLEAR, 64'h0, 64'h0, 1, '{ST_CLEARED, 8'd0, 8'd0}},
      '{MODE_LOOKUP, '1, '1, 1, '{ST_EMPTY, 8'd0, 8'd0}}
    };
    foreach (dir_tab[i])
      send_item(dir_tab[i].mode, dir_tab[i].key, dir_tab[i].hash,
                dir_tab[i].typed, dir_tab[i].want);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      write_cfg(REG_CAPACITY_LOG2, {4'd0, ph_cap[ph]});
      write_cfg(REG_MAX_ENTRIES, ph_max[ph]);
      for (int i = 0; i < POOL_N; i++) begin
        pool_key[i] = {$urandom, $urandom};
        pool_hash[i] = {$urandom, $urandom};
        if (i > 0 && $urandom_range(0, 2) == 0)
          pool_hash[i][7:0] = pool_hash[i - 1][7:0];
      end
      if (ph == 1) hold_req = 1;
      // every other phase starts without a clear: stale entries stay counted
      if (ph % 2 == 0) send_item(MODE_CLEAR, '0, '0, 0, none);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        k = $urandom_range(0, 99);
        if (k < 30) mode = MODE_GET_OR_PUT;
        else if (k < 45) mode = MODE_INSERT_NEW;
        else if (k < 70) mode = MODE_LOOKUP;
        else if (k < 92) mode = MODE_REMOVE;
        else if (k < 95) mode = MODE_CLEAR;
        else mode = $urandom_range(MODE_SPARE_LO, MODE_SPARE_HI);
        pick = $urandom_range(0, POOL_N - 1);
        key = pool_key[pick];
        hash = pool_hash[pick];
        if ($urandom_range(0, 9) == 0) begin
          key = {$urandom, $urandom};
          hash = {$urandom, $urandom};
        end
        send_item(mode, key, hash, 0, none);
      end
      settle();
    end

    if (errors == 0) begin
      $display("** linear_probe_hash_set: PASSED **");
    end else begin
      $display("** linear_probe_hash_set: FAILED **");
    end
    $finish;
  end
endmodule
